// ===== src/hbfak_pkg.sv =====
// ============================================================================
// hbfak_pkg
// Shared widths, constants, types and helper functions for the hand box
// pipeline. The internal coordinate widths follow from the fraction bit count.
// ============================================================================
`timescale 1ns / 1ps

package hbfak_pkg;

    localparam int COORD_FRAC_BITS = 16;

    localparam int CW        = COORD_FRAC_BITS + 1;
    localparam int DW        = COORD_FRAC_BITS + 2;
    localparam int PW        = COORD_FRAC_BITS + 10;
    localparam int XW        = COORD_FRAC_BITS + 6;
    localparam int WHW       = COORD_FRAC_BITS + 10;
    localparam int SW        = COORD_FRAC_BITS + 7;
    localparam int EW        = COORD_FRAC_BITS + 12;
    localparam int NW        = COORD_FRAC_BITS + 11;
    localparam int PIX_W     = 12;
    localparam int MW        = NW + PIX_W;
    localparam int VIS_W     = 16;
    localparam int AREA_W    = 24;
    localparam int ASP_W     = 10;
    localparam int QW        = 16;
    localparam int XSH       = COORD_FRAC_BITS + 10;
    localparam int YSH       = COORD_FRAC_BITS + 6;
    localparam int DIV9_SH   = 19;
    localparam int DIV9_PW   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DW    = 24;

    localparam logic [QW-1:0] DIV9_MUL = 16'd58255;

    localparam logic signed [PW-1:0] FULL32 = PW'(64'd1 << (COORD_FRAC_BITS + 5));
    localparam logic signed [EW-1:0] XFULL  = EW'(64'd1 << (COORD_FRAC_BITS + 10));
    localparam logic signed [EW-1:0] YFULL  = EW'(64'd9 << (COORD_FRAC_BITS + 6));

    localparam logic [PIX_W-1:0]  RST_FRAME_WIDTH  = 12'd1280;
    localparam logic [PIX_W-1:0]  RST_FRAME_HEIGHT = 12'd720;
    localparam logic [VIS_W-1:0]  RST_VIS_THR      = 16'd3277;
    localparam logic [AREA_W-1:0] RST_MIN_AREA     = 24'd1024;
    localparam logic [ASP_W-1:0]  RST_ASPECT_LIMIT = 10'd307;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 3'd0,
        CFG_FRAME_HEIGHT = 3'd1,
        CFG_VIS_THR      = 3'd2,
        CFG_MIN_AREA     = 3'd3,
        CFG_ASPECT_LIMIT = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic          valid;
        logic          found;
        logic [NW-1:0] x1;
        logic [NW-1:0] x2;
        logic [NW-1:0] y1;
        logic [NW-1:0] y2;
    } t_box;

    typedef struct packed {
        logic             valid;
        logic             found;
        logic             accepted;
        logic [PIX_W-1:0] left;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] right;
        logic [PIX_W-1:0] bottom;
    } t_result;

    function automatic logic signed [PW-1:0] min4(input logic signed [PW-1:0] a,
                                                  input logic signed [PW-1:0] b,
                                                  input logic signed [PW-1:0] c,
                                                  input logic signed [PW-1:0] d);
        logic signed [PW-1:0] m_ab;
        logic signed [PW-1:0] m_cd;
        m_ab = (b < a) ? b : a;
        m_cd = (d < c) ? d : c;
        return (m_cd < m_ab) ? m_cd : m_ab;
    endfunction

    function automatic logic signed [PW-1:0] max4(input logic signed [PW-1:0] a,
                                                  input logic signed [PW-1:0] b,
                                                  input logic signed [PW-1:0] c,
                                                  input logic signed [PW-1:0] d);
        logic signed [PW-1:0] m_ab;
        logic signed [PW-1:0] m_cd;
        m_ab = (b > a) ? b : a;
        m_cd = (d > c) ? d : c;
        return (m_cd > m_ab) ? m_cd : m_ab;
    endfunction

    function automatic logic [XW-1:0] clamp_corner(input logic signed [PW-1:0] v);
        if (v < 0) begin
            return '0;
        end else if (v > FULL32) begin
            return FULL32[XW-1:0];
        end
        return v[XW-1:0];
    endfunction

    function automatic logic [NW-1:0] clamp_edge(input logic signed [EW-1:0] v,
                                                 input logic signed [EW-1:0] hi);
        if (v < 0) begin
            return '0;
        end else if (v > hi) begin
            return hi[NW-1:0];
        end
        return v[NW-1:0];
    endfunction

endpackage

// ===== src/hbfak_geom.sv =====
// ============================================================================
// hbfak_geom
// Four pipeline stages from the arm keypoints to the clamped 9:16 box in
// fine normalized units: corners, bounding box, size and centre, edges.
// ============================================================================
`timescale 1ns / 1ps

module hbfak_geom (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [hbfak_pkg::CW-1:0]   i_elbow_x,
    input  logic [hbfak_pkg::CW-1:0]   i_elbow_y,
    input  logic [hbfak_pkg::VIS_W-1:0] i_elbow_vis,
    input  logic [hbfak_pkg::CW-1:0]   i_wrist_x,
    input  logic [hbfak_pkg::CW-1:0]   i_wrist_y,
    input  logic [hbfak_pkg::VIS_W-1:0] i_wrist_vis,
    input  logic [hbfak_pkg::VIS_W-1:0] i_vis_thr,
    output hbfak_pkg::t_box            o_box
);
    import hbfak_pkg::*;

    logic signed [PW-1:0] ex_e, ey_e, wx_e, wy_e, dx, dy;
    logic signed [PW-1:0] n1_px [4];
    logic signed [PW-1:0] n1_py [4];
    logic                 n1_found;

    logic                 r1_valid, r1_found;
    logic signed [PW-1:0] r1_px [4];
    logic signed [PW-1:0] r1_py [4];

    logic [XW-1:0] n2_xmin, n2_xmax, n2_ymin, n2_ymax;
    logic          r2_valid, r2_found;
    logic [XW-1:0] r2_xmin, r2_xmax, r2_ymin, r2_ymax;

    logic [XW-1:0]  bw, bh;
    logic [WHW-1:0] wa, wb, n3_wh;
    logic [SW-1:0]  n3_xs, n3_ys;
    logic           r3_valid, r3_found;
    logic [WHW-1:0] r3_wh;
    logic [SW-1:0]  r3_xs, r3_ys;

    logic signed [EW-1:0] xs_e, ys_e, wh_e, xc16, yc9;
    logic [NW-1:0]        n4_x1, n4_x2, n4_y1, n4_y2;
    logic                 r4_valid, r4_found;
    logic [NW-1:0]        r4_x1, r4_x2, r4_y1, r4_y2;

    always_comb begin
        ex_e = $signed(PW'(i_elbow_x));
        ey_e = $signed(PW'(i_elbow_y));
        wx_e = $signed(PW'(i_wrist_x));
        wy_e = $signed(PW'(i_wrist_y));
        dx   = wx_e - ex_e;
        dy   = wy_e - ey_e;
        n1_px[0] = (wx_e <<< 5) + (dy <<< 3) + dy;
        n1_py[0] = (wy_e <<< 5) - (dx <<< 3) - dx;
        n1_px[1] = (wx_e <<< 5) - (dy <<< 3) - dy;
        n1_py[1] = (wy_e <<< 5) + (dx <<< 3) + dx;
        n1_px[2] = n1_px[0] + (dx <<< 5);
        n1_py[2] = n1_py[0] + (dy <<< 5);
        n1_px[3] = n1_px[1] + (dx <<< 5);
        n1_py[3] = n1_py[1] + (dy <<< 5);
        n1_found = (i_elbow_vis > i_vis_thr) && (i_wrist_vis > i_vis_thr)
                   && ((dx != '0) || (dy != '0));
    end

    always_comb begin
        n2_xmin = clamp_corner(min4(r1_px[0], r1_px[1], r1_px[2], r1_px[3]));
        n2_xmax = clamp_corner(max4(r1_px[0], r1_px[1], r1_px[2], r1_px[3]));
        n2_ymin = clamp_corner(min4(r1_py[0], r1_py[1], r1_py[2], r1_py[3]));
        n2_ymax = clamp_corner(max4(r1_py[0], r1_py[1], r1_py[2], r1_py[3]));
    end

    always_comb begin
        bw    = r2_xmax - r2_xmin;
        bh    = r2_ymax - r2_ymin;
        wa    = WHW'(bw) << 4;
        wb    = (WHW'(bh) << 3) + WHW'(bh);
        n3_wh = (wa > wb) ? wa : wb;
        n3_xs = SW'(r2_xmin) + SW'(r2_xmax);
        n3_ys = SW'(r2_ymin) + SW'(r2_ymax);
    end

    always_comb begin
        xs_e  = $signed(EW'(r3_xs));
        ys_e  = $signed(EW'(r3_ys));
        wh_e  = $signed(EW'(r3_wh));
        xc16  = xs_e <<< 4;
        yc9   = (ys_e <<< 3) + ys_e;
        n4_x1 = clamp_edge(xc16 - wh_e, XFULL);
        n4_x2 = clamp_edge(xc16 + wh_e, XFULL);
        n4_y1 = clamp_edge(yc9 - wh_e, YFULL);
        n4_y2 = clamp_edge(yc9 + wh_e, YFULL);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_found <= n1_found;
        r1_px    <= n1_px;
        r1_py    <= n1_py;
        r2_found <= r1_found;
        r2_xmin  <= n2_xmin;
        r2_xmax  <= n2_xmax;
        r2_ymin  <= n2_ymin;
        r2_ymax  <= n2_ymax;
        r3_found <= r2_found;
        r3_wh    <= n3_wh;
        r3_xs    <= n3_xs;
        r3_ys    <= n3_ys;
        r4_found <= r3_found;
        r4_x1    <= n4_x1;
        r4_x2    <= n4_x2;
        r4_y1    <= n4_y1;
        r4_y2    <= n4_y2;
    end

    assign o_box = '{valid: r4_valid, found: r4_found,
                     x1: r4_x1, x2: r4_x2, y1: r4_y1, y2: r4_y2};

endmodule

// ===== src/hbfak_scale.sv =====
// ============================================================================
// hbfak_scale
// Five pipeline stages from the normalized box to pixels: sizes, frame
// scaling, division of the rows by nine, check products, and the final
// area and aspect decision into the result register.
// ============================================================================
`timescale 1ns / 1ps

module hbfak_scale (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  hbfak_pkg::t_box              i_box,
    input  logic [hbfak_pkg::PIX_W-1:0]  i_frame_width,
    input  logic [hbfak_pkg::PIX_W-1:0]  i_frame_height,
    input  logic [hbfak_pkg::AREA_W-1:0] i_min_area,
    input  logic [hbfak_pkg::ASP_W-1:0]  i_aspect_limit,
    output hbfak_pkg::t_result           o_result
);
    import hbfak_pkg::*;

    localparam int CW22 = ASP_W + PIX_W;
    localparam int RW20 = PIX_W + 8;

    logic          r5_valid, r5_found;
    logic [NW-1:0] r5_x1, r5_x2, r5_y1, r5_y2, r5_w, r5_h;

    logic [MW-1:0]    m_x1, m_x2, m_y1, m_y2, m_w, m_h;
    logic             r6_valid, r6_found;
    logic [PIX_W-1:0] r6_px1, r6_px2, r6_rw;
    logic [QW-1:0]    r6_qy1, r6_qy2, r6_qh;

    logic [DIV9_PW-1:0] d_y1, d_y2, d_h;
    logic               r7_valid, r7_found;
    logic [PIX_W-1:0]   r7_px1, r7_px2, r7_rw, r7_py1, r7_py2, r7_rh;

    logic [AREA_W-1:0] n8_area;
    logic [CW22-1:0]   n8_alw, n8_alh;
    logic              r8_valid, r8_found;
    logic [AREA_W-1:0] r8_area;
    logic [CW22-1:0]   r8_alw, r8_alh;
    logic [PIX_W-1:0]  r8_px1, r8_px2, r8_py1, r8_py2, r8_rw, r8_rh;

    logic [RW20-1:0] rw256, rh256;
    logic            n9_ok;
    t_result         r9_res;

    always_comb begin
        m_x1 = MW'(r5_x1) * MW'(i_frame_width);
        m_x2 = MW'(r5_x2) * MW'(i_frame_width);
        m_w  = MW'(r5_w) * MW'(i_frame_width);
        m_y1 = MW'(r5_y1) * MW'(i_frame_height);
        m_y2 = MW'(r5_y2) * MW'(i_frame_height);
        m_h  = MW'(r5_h) * MW'(i_frame_height);
    end

    always_comb begin
        d_y1 = DIV9_PW'(r6_qy1) * DIV9_PW'(DIV9_MUL);
        d_y2 = DIV9_PW'(r6_qy2) * DIV9_PW'(DIV9_MUL);
        d_h  = DIV9_PW'(r6_qh) * DIV9_PW'(DIV9_MUL);
    end

    always_comb begin
        n8_area = AREA_W'(r7_rw) * AREA_W'(r7_rh);
        n8_alw  = CW22'(i_aspect_limit) * CW22'(r7_rw);
        n8_alh  = CW22'(i_aspect_limit) * CW22'(r7_rh);
    end

    always_comb begin
        rw256 = {r8_rw, 8'b0};
        rh256 = {r8_rh, 8'b0};
        n9_ok = r8_found && (r8_area >= i_min_area)
                && (r8_rw != '0) && (r8_rh != '0)
                && (CW22'(rh256) <= r8_alw)
                && (r8_alh >= CW22'(rw256));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid     <= 1'b0;
            r6_valid     <= 1'b0;
            r7_valid     <= 1'b0;
            r8_valid     <= 1'b0;
            r9_res.valid <= 1'b0;
        end else begin
            r5_valid     <= i_box.valid;
            r6_valid     <= r5_valid;
            r7_valid     <= r6_valid;
            r8_valid     <= r7_valid;
            r9_res.valid <= r8_valid;
        end

        r9_res.found    <= r8_found;
        r9_res.accepted <= n9_ok;
        r9_res.left     <= n9_ok ? r8_px1 : '0;
        r9_res.right    <= n9_ok ? r8_px2 : '0;
        r9_res.top      <= n9_ok ? r8_py1 : '0;
        r9_res.bottom   <= n9_ok ? r8_py2 : '0;
    end

    always_ff @(posedge i_clk) begin
        r5_found <= i_box.found;
        r5_x1    <= i_box.x1;
        r5_x2    <= i_box.x2;
        r5_y1    <= i_box.y1;
        r5_y2    <= i_box.y2;
        r5_w     <= i_box.x2 - i_box.x1;
        r5_h     <= i_box.y2 - i_box.y1;

        r6_found <= r5_found;
        r6_px1   <= m_x1[XSH+PIX_W-1:XSH];
        r6_px2   <= m_x2[XSH+PIX_W-1:XSH];
        r6_rw    <= m_w[XSH+PIX_W-1:XSH];
        r6_qy1   <= m_y1[YSH+QW-1:YSH];
        r6_qy2   <= m_y2[YSH+QW-1:YSH];
        r6_qh    <= m_h[YSH+QW-1:YSH];

        r7_found <= r6_found;
        r7_px1   <= r6_px1;
        r7_px2   <= r6_px2;
        r7_rw    <= r6_rw;
        r7_py1   <= d_y1[DIV9_SH+PIX_W-1:DIV9_SH];
        r7_py2   <= d_y2[DIV9_SH+PIX_W-1:DIV9_SH];
        r7_rh    <= d_h[DIV9_SH+PIX_W-1:DIV9_SH];

        r8_found <= r7_found;
        r8_area  <= n8_area;
        r8_alw   <= n8_alw;
        r8_alh   <= n8_alh;
        r8_px1   <= r7_px1;
        r8_px2   <= r7_px2;
        r8_py1   <= r7_py1;
        r8_py2   <= r7_py2;
        r8_rw    <= r7_rw;
        r8_rh    <= r7_rh;
    end

    assign o_result = r9_res;

endmodule

// ===== src/hand_box_from_arm_keypoints_core.sv =====
// ============================================================================
// hand_box_from_arm_keypoints_core
// Each start is registered through the hbfak_geom stages and then the
// hbfak_scale stages into the result word; o_valid is high for exactly one cycle.
// Throughput: one arm per clock; busy stays low since every stage advances
// each cycle and the receiver cannot stall.
// Reset: synchronous active-low reset clears all valid bits and loads the
// register defaults of 1280, 720, 3277, 1024 and 307.
// ============================================================================
`timescale 1ns / 1ps

module hand_box_from_arm_keypoints_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [hbfak_pkg::CW-1:0]        i_elbow_x,
    input  logic [hbfak_pkg::CW-1:0]        i_elbow_y,
    input  logic [hbfak_pkg::VIS_W-1:0]     i_elbow_vis,
    input  logic [hbfak_pkg::CW-1:0]        i_wrist_x,
    input  logic [hbfak_pkg::CW-1:0]        i_wrist_y,
    input  logic [hbfak_pkg::VIS_W-1:0]     i_wrist_vis,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [hbfak_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [hbfak_pkg::CFG_DW-1:0]    i_cfg_data,
    output logic                            o_valid,
    output logic                            o_box_found,
    output logic                            o_box_accepted,
    output logic [hbfak_pkg::PIX_W-1:0]     o_roi_left,
    output logic [hbfak_pkg::PIX_W-1:0]     o_roi_top,
    output logic [hbfak_pkg::PIX_W-1:0]     o_roi_right,
    output logic [hbfak_pkg::PIX_W-1:0]     o_roi_bottom
);
    import hbfak_pkg::*;

    logic [PIX_W-1:0]  r_frame_width, r_frame_height;
    logic [VIS_W-1:0]  r_vis_thr;
    logic [AREA_W-1:0] r_min_area;
    logic [ASP_W-1:0]  r_aspect_limit;
    logic              cfg_wr;
    t_box              box;
    t_result           result;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_vis_thr      <= RST_VIS_THR;
            r_min_area     <= RST_MIN_AREA;
            r_aspect_limit <= RST_ASPECT_LIMIT;
        end else if (cfg_wr) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[PIX_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[PIX_W-1:0];
                CFG_VIS_THR:      r_vis_thr      <= i_cfg_data[VIS_W-1:0];
                CFG_MIN_AREA:     r_min_area     <= i_cfg_data[AREA_W-1:0];
                CFG_ASPECT_LIMIT: r_aspect_limit <= i_cfg_data[ASP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    hbfak_geom u_geom (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (start && !busy),
        .i_elbow_x   (i_elbow_x),
        .i_elbow_y   (i_elbow_y),
        .i_elbow_vis (i_elbow_vis),
        .i_wrist_x   (i_wrist_x),
        .i_wrist_y   (i_wrist_y),
        .i_wrist_vis (i_wrist_vis),
        .i_vis_thr   (r_vis_thr),
        .o_box       (box)
    );

    hbfak_scale u_scale (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_box          (box),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_min_area     (r_min_area),
        .i_aspect_limit (r_aspect_limit),
        .o_result       (result)
    );

    assign o_valid        = result.valid;
    assign o_box_found    = result.found;
    assign o_box_accepted = result.accepted;
    assign o_roi_left     = result.left;
    assign o_roi_top      = result.top;
    assign o_roi_right    = result.right;
    assign o_roi_bottom   = result.bottom;

endmodule

// ===== src/hbfak_checker.sv =====
// ============================================================================
// hbfak_checker
// Port-level checks of the hand box core: fixed latency, clean reset, and
// consistency of the found, accepted and pixel fields of each result word.
// ============================================================================
`timescale 1ns / 1ps

module hbfak_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            start,
    input logic                            busy,
    input logic                            o_valid,
    input logic                            o_box_found,
    input logic                            o_box_accepted,
    input logic [hbfak_pkg::PIX_W-1:0]     o_roi_left,
    input logic [hbfak_pkg::PIX_W-1:0]     o_roi_top,
    input logic [hbfak_pkg::PIX_W-1:0]     o_roi_right,
    input logic [hbfak_pkg::PIX_W-1:0]     o_roi_bottom
);

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##9 o_valid)
        else $error("result word missing nine edges after start");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

    a_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_box_found) |-> !o_box_accepted)
        else $error("box accepted although none was found");

    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_box_accepted) |->
        (o_roi_left == '0 && o_roi_top == '0 && o_roi_right == '0 && o_roi_bottom == '0))
        else $error("rejected box carries pixel edges");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_box_accepted) |->
        (o_roi_right >= o_roi_left && o_roi_bottom >= o_roi_top))
        else $error("accepted box edges out of order");

endmodule

bind hand_box_from_arm_keypoints_core hbfak_checker u_hbfak_checker (.*);
